// ===== rtl/core/kt_pkg.sv =====
// Shared constants, codes and transfer types of the keyed tally table.
package kt_pkg;

  // Table geometry.
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int KEY_W   = 14;
  localparam int TOTAL_W = 32;
  localparam int QTY_W   = 16;

  // Valid key range.
  localparam logic [KEY_W-1:0] KEY_LOW  = KEY_W'(1000);
  localparam logic [KEY_W-1:0] KEY_HIGH = KEY_W'(9999);

  // Request codes.
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_LISTED   = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  // List kinds of a listed result.
  localparam logic KIND_MAX = 1'b0;
  localparam logic KIND_MIN = 1'b1;

  // One request.
  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key_code;
    logic [QTY_W-1:0] quantity;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [2:0]         status;
    logic               list_kind;
    logic [KEY_W-1:0]   entry_key;
    logic [TOTAL_W-1:0] entry_total;
    logic               last;
  } out_item_t;

endpackage

// ===== rtl/core/kt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/keyed_tally_table_top.sv =====
// Top level of the keyed tally table: sequencer, scan unit and entry stores.
//
// Usage: a request is taken at a rising edge where start is high and busy
// is low; in_item carries req_type, key_code and quantity. Results appear
// on out_item for exactly one cycle each, marked by out_valid, and the
// receiver cannot hold them off. The final result of a request has last set.
// Requests with a bad key, a zero add quantity, an unknown type, or a report
// on an empty table are answered in the cycle after the transfer and busy
// never rises. Load and add requests scan the n loaded entries through
// the single read port of the stores and the one result comes out as busy
// falls. A report makes three scans over the entries (min/max search,
// maximum list, minimum list); listed results come out during the scans,
// the final one as busy falls. The scans read one entry per cycle
// through the memory read port.
// Reset clears the fill count and the sequencer; stores need no clearing
// since only entries below the fill count are ever read.
module keyed_tally_table_top
  import kt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_MINMAX = 2'd2;
  localparam logic [1:0] S_LIST   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  in_item_t           req_r, req_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  logic [TOTAL_W-1:0] found_total_r, found_total_nxt;
  logic [TOTAL_W-1:0] mx_r, mx_nxt;
  logic [TOTAL_W-1:0] mn_r, mn_nxt;
  logic               pass_r, pass_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  out_item_t          pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               key_we, total_we;
  logic [IDX_W-1:0]   key_waddr, total_waddr;
  logic [KEY_W-1:0]   key_wdata, key_rdata;
  logic [TOTAL_W-1:0] total_wdata, total_rdata;

  logic               in_key_ok;
  logic               scan_done;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] target;

  // Entry stores share one read address: the scan pointer.
  kt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  kt_ram #(.WIDTH(TOTAL_W), .DEPTH(ENTRIES)) u_total_ram (
    .clk   (clk),
    .we    (total_we),
    .waddr (total_waddr),
    .wdata (total_wdata),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (total_rdata)
  );

  // Key range check of the incoming request.
  assign in_key_ok = (in_item.key_code >= KEY_LOW) && (in_item.key_code <= KEY_HIGH);

  // A scan is over once every loaded entry has been issued and read back.
  assign scan_done = (scan_idx_r == count_r) && !rd_vld_r;

  // Saturating adder for the add request.
  assign sum    = {1'b0, found_total_r} + {{(TOTAL_W + 1 - QTY_W){1'b0}}, req_r.quantity};
  assign target = pass_r ? mn_r : mx_r;

  // Sequencer and scan datapath.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    scan_idx_nxt    = scan_idx_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    req_nxt         = req_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    found_total_nxt = found_total_r;
    mx_nxt          = mx_r;
    mn_nxt          = mn_r;
    pass_nxt        = pass_r;
    pend_vld_nxt    = pend_vld_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = '0;
    key_we          = 1'b0;
    key_waddr       = count_r[IDX_W-1:0];
    key_wdata       = req_r.key_code;
    total_we        = 1'b0;
    total_waddr     = count_r[IDX_W-1:0];
    total_wdata     = '0;

    // Issue the next read while a scan is running.
    if (state_r != S_IDLE && scan_idx_r != count_r) begin
      rd_vld_nxt   = 1'b1;
      rd_idx_nxt   = scan_idx_r[IDX_W-1:0];
      scan_idx_nxt = scan_idx_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt       = in_item;
          scan_idx_nxt  = '0;
          found_nxt     = 1'b0;
          pend_vld_nxt  = 1'b0;
          pass_nxt      = KIND_MAX;
          out_item_nxt.last = 1'b1;
          case (in_item.req_type)
            REQ_LOAD: begin
              if (!in_key_ok) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_INVALID;
              end else begin
                state_nxt = S_LOOKUP;
              end
            end
            REQ_ADD: begin
              if (!in_key_ok || in_item.quantity == '0) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_INVALID;
              end else begin
                state_nxt = S_LOOKUP;
              end
            end
            REQ_REPORT: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_MINMAX;
              end
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_INVALID;
            end
          endcase
        end
      end

      S_LOOKUP: begin
        // Note the first loaded entry that holds the key.
        if (rd_vld_r && !found_r && key_rdata == req_r.key_code) begin
          found_nxt       = 1'b1;
          found_idx_nxt   = rd_idx_r;
          found_total_nxt = total_rdata;
        end
        if (scan_done) begin
          state_nxt         = S_IDLE;
          out_valid_nxt     = 1'b1;
          out_item_nxt.last = 1'b1;
          if (req_r.req_type == REQ_LOAD) begin
            if (found_r) begin
              out_item_nxt.status      = ST_DUP;
              out_item_nxt.entry_key   = req_r.key_code;
              out_item_nxt.entry_total = found_total_r;
            end else if (count_r >= CNT_W'(ENTRIES)) begin
              out_item_nxt.status = ST_FULL;
            end else begin
              key_we                 = 1'b1;
              total_we               = 1'b1;
              count_nxt              = count_r + CNT_W'(1);
              out_item_nxt.status    = ST_OK;
              out_item_nxt.entry_key = req_r.key_code;
            end
          end else begin
            if (found_r) begin
              total_we                 = 1'b1;
              total_waddr              = found_idx_r;
              total_wdata              = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
              out_item_nxt.status      = ST_OK;
              out_item_nxt.entry_key   = req_r.key_code;
              out_item_nxt.entry_total = total_wdata;
            end else begin
              out_item_nxt.status = ST_NOTFOUND;
            end
          end
        end
      end

      S_MINMAX: begin
        // Running maximum and minimum over the loaded totals.
        if (rd_vld_r) begin
          if (rd_idx_r == '0) begin
            mx_nxt = total_rdata;
            mn_nxt = total_rdata;
          end else begin
            if (total_rdata > mx_r) begin
              mx_nxt = total_rdata;
            end
            if (total_rdata < mn_r) begin
              mn_nxt = total_rdata;
            end
          end
        end
        if (scan_done) begin
          state_nxt    = S_LIST;
          scan_idx_nxt = '0;
          pass_nxt     = KIND_MAX;
        end
      end

      S_LIST: begin
        // Maximum list goes out at once; the minimum list is held back by
        // one entry so that its final entry can carry the last flag.
        if (rd_vld_r && total_rdata == target) begin
          if (pass_r == KIND_MAX) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.status      = ST_LISTED;
            out_item_nxt.list_kind   = KIND_MAX;
            out_item_nxt.entry_key   = key_rdata;
            out_item_nxt.entry_total = total_rdata;
          end else begin
            out_valid_nxt            = pend_vld_r;
            out_item_nxt             = pend_r;
            pend_vld_nxt             = 1'b1;
            pend_nxt                 = '0;
            pend_nxt.status          = ST_LISTED;
            pend_nxt.list_kind       = KIND_MIN;
            pend_nxt.entry_key       = key_rdata;
            pend_nxt.entry_total     = total_rdata;
          end
        end
        if (scan_done) begin
          if (pass_r == KIND_MAX) begin
            pass_nxt     = KIND_MIN;
            scan_idx_nxt = '0;
          end else begin
            state_nxt         = S_IDLE;
            out_valid_nxt     = 1'b1;
            out_item_nxt      = pend_r;
            out_item_nxt.last = 1'b1;
            pend_vld_nxt      = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r    <= scan_idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    req_r         <= req_nxt;
    found_r       <= found_nxt;
    found_idx_r   <= found_idx_nxt;
    found_total_r <= found_total_nxt;
    mx_r          <= mx_nxt;
    mn_r          <= mn_nxt;
    pass_r        <= pass_nxt;
    pend_r        <= pend_nxt;
    out_item_r    <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/kt_checker.sv =====
// Port-level checker of the keyed tally table and its bind statement.
module kt_checker
  import kt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // Every accepted request either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted request dropped");

  // A result without the last flag comes while the request is still in progress.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("request ended without a last result");

  // Only listed results come in series; everything else is single and plain.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_LISTED |-> out_item.last && !out_item.list_kind)
    else $error("non-listed result malformed");

  // When busy falls, the final result of the request goes out in the same cycle.
  a_end_result: assert property (@(posedge clk)
    rst_n && $past(rst_n) && $fell(busy) |-> out_valid && out_item.last)
    else $error("busy fell without a final result");

endmodule

bind keyed_tally_table_top kt_checker u_kt_checker (.*);

// ===== tb/keyed_tally_table_top_tb.sv =====
// Self-checking testbench of the keyed tally table: directed and random requests.
module keyed_tally_table_top_tb;
  import kt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block does not define; it must be answered as invalid.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Full-scale adds on one key, enough to carry into the upper bits of its total.
  localparam int FULL_SCALE_ADDS = 24;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 3 * ENTRIES + 14;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Shadow copy of the table as the block should hold it.
  logic [KEY_W-1:0]   table_keys [ENTRIES];
  logic [TOTAL_W-1:0] table_totals [ENTRIES];
  int                 table_fill;

  out_item_t awaited_results [$];
  int        failures = 0;
  int        quiet_cycles = 0;
  bit        gaps_enabled;

  keyed_tally_table_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // Position of a loaded key, or -1 when it is not in the table.
  function automatic int find_entry(input logic [KEY_W-1:0] key);
    for (int i = 0; i < table_fill; i++) begin
      if (table_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Work out the results of one accepted request and update the shadow table.
  function automatic void tally_request(input in_item_t req);
    out_item_t          r;
    int                 pos;
    int                 listed;
    int                 n;
    bit                 key_ok;
    logic [TOTAL_W-1:0] hi;
    logic [TOTAL_W-1:0] lo;
    logic [TOTAL_W-1:0] target;
    logic [TOTAL_W:0]   sum;
    r = '0;
    r.last = 1'b1;
    key_ok = (req.key_code >= KEY_LOW) && (req.key_code <= KEY_HIGH);
    pos = find_entry(req.key_code);
    case (req.req_type)
      REQ_LOAD: begin
        if (!key_ok) begin
          r.status = ST_INVALID;
        end else if (pos >= 0) begin
          r.status      = ST_DUP;
          r.entry_key   = req.key_code;
          r.entry_total = table_totals[pos];
        end else if (table_fill >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          table_keys[table_fill]   = req.key_code;
          table_totals[table_fill] = '0;
          table_fill++;
          r.status    = ST_OK;
          r.entry_key = req.key_code;
        end
      end
      REQ_ADD: begin
        if (!key_ok || req.quantity == '0) begin
          r.status = ST_INVALID;
        end else if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          sum = {1'b0, table_totals[pos]} + req.quantity;
          table_totals[pos] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          r.status      = ST_OK;
          r.entry_key   = req.key_code;
          r.entry_total = table_totals[pos];
        end
      end
      REQ_REPORT: begin
        if (table_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hi = table_totals[0];
          lo = table_totals[0];
          for (int i = 1; i < table_fill; i++) begin
            if (table_totals[i] > hi) hi = table_totals[i];
            if (table_totals[i] < lo) lo = table_totals[i];
          end
          listed = 0;
          for (int i = 0; i < table_fill; i++) begin
            if (table_totals[i] == hi) listed++;
            if (table_totals[i] == lo) listed++;
          end
          // Entries at the maximum in table order, then those at the minimum.
          n = 0;
          for (int pass = 0; pass < 2; pass++) begin
            target = (pass == 0) ? hi : lo;
            for (int i = 0; i < table_fill; i++) begin
              if (table_totals[i] == target) begin
                n++;
                r.status      = ST_LISTED;
                r.list_kind   = (pass == 0) ? KIND_MAX : KIND_MIN;
                r.entry_key   = table_keys[i];
                r.entry_total = table_totals[i];
                r.last        = (n == listed);
                awaited_results.push_back(r);
              end
            end
          end
          return;
        end
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    awaited_results.push_back(r);
  endfunction

  // Offer one request, with an optional random gap before it, and wait for the transfer.
  task automatic send_request(input in_item_t req);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    tally_request(req);
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                             input logic [QTY_W-1:0] qty);
    in_item_t req;
    req.req_type = kind;
    req.key_code = key;
    req.quantity = qty;
    send_request(req);
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] key;
    do key = KEY_W'($urandom_range(KEY_LOW, KEY_HIGH)); while (find_entry(key) >= 0);
    return key;
  endfunction

  function automatic logic [KEY_W-1:0] bad_key();
    if ($urandom_range(0, 1) == 0) return KEY_W'($urandom_range(0, KEY_LOW - 1));
    return KEY_W'($urandom_range(KEY_HIGH + 1, (1 << KEY_W) - 1));
  endfunction

  function automatic logic [KEY_W-1:0] loaded_key();
    return table_keys[$urandom_range(0, table_fill - 1)];
  endfunction

  // Small quantities make ties between totals likely; large ones exercise all bits.
  function automatic logic [QTY_W-1:0] pick_quantity();
    case ($urandom_range(0, 3))
      0:       return QTY_W'($urandom_range(1, 3));
      1:       return QTY_W'($urandom_range(1, (1 << QTY_W) - 1));
      2:       return '1;
      default: return QTY_W'($urandom);
    endcase
  endfunction

  // Requests on an empty table, bad keys, a zero quantity and the unused code.
  task automatic test_empty_table();
    send_fields(REQ_REPORT, '0, '0);
    send_fields(REQ_UNUSED, '1, '1);
    send_fields(REQ_LOAD, '0, '0);
    send_fields(REQ_LOAD, KEY_LOW - 1, 16'd5);
    send_fields(REQ_LOAD, KEY_HIGH + 1, 16'd5);
    send_fields(REQ_LOAD, '1, '1);
    send_fields(REQ_ADD, KEY_LOW, '0);
    send_fields(REQ_ADD, '1, 16'd1);
    send_fields(REQ_ADD, KEY_LOW, 16'd1);
  endtask

  // First loads, duplicates, and reports where maximum and minimum coincide.
  task automatic test_first_entries();
    send_fields(REQ_LOAD, KEY_LOW, '1);
    send_fields(REQ_LOAD, KEY_LOW, '0);
    send_fields(REQ_REPORT, '1, '1);
    send_fields(REQ_LOAD, KEY_HIGH, '0);
    send_fields(REQ_REPORT, '0, '0);
    send_fields(REQ_ADD, KEY_HIGH, 16'd1);
    send_fields(REQ_ADD, KEY_HIGH + 1, 16'd1);
    send_fields(REQ_ADD, KEY_LOW - 1, 16'd1);
    send_fields(REQ_LOAD, KEY_HIGH, '1);
    send_fields(REQ_REPORT, '0, '0);
    send_fields(REQ_ADD, KEY_LOW + 1, 16'd7);
  endtask

  // Drive one total well up with a run of full-scale adds.
  task automatic test_large_totals();
    for (int i = 0; i < FULL_SCALE_ADDS; i++) send_fields(REQ_ADD, KEY_LOW, '1);
    send_fields(REQ_ADD, KEY_LOW, 16'd1);
    send_fields(REQ_LOAD, KEY_LOW, '0);
    send_fields(REQ_REPORT, '0, '0);
  endtask

  // Mostly well-formed loads, adds and reports with random content, plus noise.
  task automatic test_random_traffic(input int count);
    in_item_t req;
    int       sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      req = in_item_t'($urandom);
      if (sel < 20) begin
        req.req_type = REQ_LOAD;
        if (table_fill > 0 && $urandom_range(0, 4) == 0) req.key_code = loaded_key();
        else if ($urandom_range(0, 9) == 0) req.key_code = bad_key();
        else req.key_code = fresh_key();
      end else if (sel < 75) begin
        req.req_type = REQ_ADD;
        sel = $urandom_range(0, 9);
        if (table_fill > 0 && sel < 8) req.key_code = loaded_key();
        else if (sel == 8) req.key_code = fresh_key();
        else req.key_code = bad_key();
        req.quantity = ($urandom_range(0, 19) == 0) ? '0 : pick_quantity();
      end else if (sel < 85) begin
        req.req_type = REQ_REPORT;
      end
      send_request(req);
    end
  endtask

  // Fill the table, then a new key, a known key and a bad key against a full table, then an add and a report.
  task automatic test_full_table();
    while (table_fill < ENTRIES) send_fields(REQ_LOAD, fresh_key(), pick_quantity());
    send_fields(REQ_LOAD, fresh_key(), '0);
    send_fields(REQ_LOAD, loaded_key(), '0);
    send_fields(REQ_LOAD, bad_key(), '0);
    send_fields(REQ_ADD, table_keys[ENTRIES - 1], 16'd2);
    send_fields(REQ_REPORT, '0, '0);
  endtask

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        if (failures < 10) begin
          $display("unexpected result: status %0d kind %0d key %0d total %0d last %0d",
                   out_item.status, out_item.list_kind, out_item.entry_key,
                   out_item.entry_total, out_item.last);
        end
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (out_item.status !== want.status || out_item.list_kind !== want.list_kind ||
            out_item.entry_key !== want.entry_key ||
            out_item.entry_total !== want.entry_total || out_item.last !== want.last) begin
          if (failures < 10) begin
            $display("result mismatch: status %0d/%0d kind %0d/%0d key %0d/%0d",
                     want.status, out_item.status, want.list_kind, out_item.list_kind,
                     want.entry_key, out_item.entry_key);
            $display("  total %0d/%0d last %0d/%0d (expected/actual)",
                     want.entry_total, out_item.entry_total, want.last, out_item.last);
          end
          failures++;
        end
      end
    end
  end

  // End the run when neither side has made a transfer for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    table_fill   = 0;
    gaps_enabled = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_first_entries();
    test_large_totals();
    gaps_enabled = 1'b1;
    test_random_traffic(80);
    wait_for_results();
    test_random_traffic(60);
    test_full_table();
    gaps_enabled = 1'b0;
    test_random_traffic(80);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
